@@ rtl/core/rtu_frame_receiver_macros.svh @@
// Assertion macros shared by the RTU frame receiver RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef RTU_FRAME_RECEIVER_MACROS_SVH
`define RTU_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rtu_rx_pkg.sv @@
// Package for the RTU frame receiver: command and mode codes, widths and types.
// Used by rtu_frame_receiver; depends on nothing.
`default_nettype none

package rtu_rx_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 256;
    localparam int FRAME_LENGTH_W          = 9;

    typedef logic [1:0] cmd_t;
    typedef logic [1:0] mode_t;

    localparam cmd_t CMD_BYTE     = 2'd0;
    localparam cmd_t CMD_GAP_1P5  = 2'd1;
    localparam cmd_t CMD_GAP_3P5  = 2'd2;
    localparam cmd_t CMD_READ     = 2'd3;

    localparam mode_t MODE_IDLE      = 2'd0;
    localparam mode_t MODE_RECEIVING = 2'd1;
    localparam mode_t MODE_INVALID   = 2'd2;

endpackage

`default_nettype wire

@@ rtl/core/rtu_frame_receiver.sv @@
// RTU frame receiver top level: mode control, frame byte store and result pipeline.
// Depends on rtu_rx_pkg and rtu_frame_receiver_macros.svh.
//
// The block takes one beat per cycle while in_stall is low and returns exactly one result
// beat for each, through the pipeline register and then the output register. The frame
// bytes sit in a single memory with one write or one registered read per cycle; that
// memory read is registered alongside the pipeline register. Mode, byte count and held
// length update at the cycle of acceptance, so consecutive beats need no interlock. When
// the output stalls, the block holds one result in flight plus one in the output
// register before it stalls its input.
`default_nettype none

`include "rtu_frame_receiver_macros.svh"

module rtu_frame_receiver #(
    parameter int MAX_FRAME_BYTES = rtu_rx_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire rtu_rx_pkg::cmd_t                   cmd,
    input  wire logic [7:0]                         data_byte,
    input  wire logic [7:0]                         read_index,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    frame_ready,
    output logic [rtu_rx_pkg::FRAME_LENGTH_W-1:0]   frame_size,
    output logic [7:0]                              read_data,
    output rtu_rx_pkg::mode_t                       receiver_mode
);
    import rtu_rx_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);

    typedef struct packed {
        logic                       ready;
        logic [FRAME_LENGTH_W-1:0]  length;
        mode_t                      mode;
        logic                       rd_hit;
    } stage_t;

    mode_t           mode_reg, mode_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   held_reg, held_next;

    logic            p_valid_reg;
    stage_t          p_reg, p_next;

    logic            o_valid_reg;
    logic            o_ready_reg;
    logic [FRAME_LENGTH_W-1:0] o_length_reg;
    logic [7:0]      o_data_reg;
    mode_t           o_mode_reg;

    logic [7:0]      store_mem [MAX_FRAME_BYTES];
    logic [7:0]      mem_rdata_reg;

    logic            in_acc;
    logic            p_move;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;

    assign p_move   = p_valid_reg && (!o_valid_reg || !out_stall);
    assign in_stall = p_valid_reg && !p_move;
    assign in_acc   = in_valid && !in_stall;

    assign mem_waddr = AW'(count_reg);
    assign mem_raddr = AW'(read_index);

    always_comb
    begin
        mode_t m;
        logic  hit;
        m          = mode_reg;
        count_next = count_reg;
        held_next  = held_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        hit        = 1'b0;
        p_next     = '0;
        if (in_acc)
        begin
            case (cmd)
                CMD_BYTE:
                begin
                    if (m == MODE_IDLE)
                    begin
                        m          = MODE_RECEIVING;
                        count_next = '0;
                    end
                    if (m == MODE_RECEIVING)
                    begin
                        if (count_next >= MAX_COUNT)
                        begin
                            m = MODE_INVALID;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_next + 1'b1;
                        end
                    end
                end
                CMD_GAP_1P5:
                begin
                    if (m == MODE_RECEIVING)
                    begin
                        m = MODE_INVALID;
                    end
                end
                CMD_GAP_3P5:
                begin
                    if (m == MODE_RECEIVING)
                    begin
                        p_next.ready = 1'b1;
                        held_next    = count_reg;
                    end
                    m          = MODE_IDLE;
                    count_next = '0;
                end
                default:
                begin
                    hit = (32'(read_index) < 32'(held_reg))
                          && (32'(read_index) < MAX_FRAME_BYTES);
                    mem_re = hit;
                end
            endcase
        end
        mode_next     = m;
        p_next.length = FRAME_LENGTH_W'(held_next);
        p_next.mode   = m;
        p_next.rd_hit = hit;
    end

    // A byte is written at the address of the pre-update count, which equals
    // zero when the frame starts because count_reg is zero whenever idle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= data_byte;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= store_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            count_reg   <= '0;
            held_reg    <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            if (in_acc)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            p_reg <= p_next;
        end
        if (p_move)
        begin
            o_ready_reg  <= p_reg.ready;
            o_length_reg <= p_reg.length;
            o_mode_reg   <= p_reg.mode;
            o_data_reg   <= p_reg.rd_hit ? mem_rdata_reg : 8'd0;
        end
    end

    assign out_valid     = o_valid_reg;
    assign frame_ready   = o_ready_reg;
    assign frame_size    = o_length_reg;
    assign read_data     = o_data_reg;
    assign receiver_mode = o_mode_reg;

    `RTU_ASSERT_NOW(a_ready_means_idle, out_valid && frame_ready,
        receiver_mode == MODE_IDLE, "Frame reported without a return to idle.")
    `RTU_ASSERT_NOW(a_stall_needs_work, in_stall, p_valid_reg && o_valid_reg,
        "Input stalled while the pipeline has room.")
    `RTU_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= MAX_COUNT,
        "Byte count exceeds the frame size.")
    `RTU_ASSERT_NEXT(a_byte_counts,
        in_acc && cmd == CMD_BYTE && mode_reg == MODE_RECEIVING && count_reg < MAX_COUNT,
        count_reg == $past(count_reg) + 1'b1, "Stored byte did not advance the count.")
    `RTU_ASSERT_NOW(a_idle_count_zero, mode_reg == MODE_IDLE, count_reg == '0,
        "Idle mode with a nonzero byte count.")

endmodule

`default_nettype wire

@@ tb/sv/tb_rtu_frame_receiver.sv @@
// Self-checking testbench for rtu_frame_receiver: directed and random byte, gap and read beats
// with random idle bursts on both channels, checked against an in-line frame predictor.
// Depends on rtu_rx_pkg and the rtu_frame_receiver RTL.
`default_nettype none

module tb_rtu_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import rtu_rx_pkg::*;

    localparam int FRAME_CAP    = DEFAULT_MAX_FRAME_BYTES;
    localparam int RANDOM_BEATS = 2000;
    localparam int CALM_TAIL    = 150;
    localparam int TIMEOUT_NS   = 20_000_000;

    typedef struct {
        cmd_t       op;
        logic [7:0] data;
        logic [7:0] idx;
        bit         pause;
    } frame_item_t;

    typedef struct {
        logic                      ready;
        logic [FRAME_LENGTH_W-1:0] length;
        logic [7:0]                rdata;
        mode_t                     mode;
    } rx_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    cmd_t                      cmd = CMD_BYTE;
    logic [7:0]                data_byte = 8'd0;
    logic [7:0]                read_index = 8'd0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      frame_ready;
    logic [FRAME_LENGTH_W-1:0] frame_size;
    logic [7:0]                read_data;
    mode_t                     receiver_mode;

    frame_item_t pending_beats[$];
    rx_result_t  expected_results[$];

    mode_t      rx_mode;
    int         rx_count;
    int         rx_held;
    logic [7:0] rx_store [FRAME_CAP];

    int  mismatches = 0;
    int  beats_total = 0;
    int  beats_accepted = 0;
    int  results_checked = 0;
    int  frames_reported = 0;
    int  reads_in_range = 0;
    int  overflow_hits = 0;
    int  longest_frame = 0;
    bit  beat_taken = 1'b0;
    int  in_gap_left = 0;
    int  out_gap_left = 0;
    bit  hold_next = 1'b0;
    frame_item_t next_beat;

    rtu_frame_receiver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .data_byte     (data_byte),
        .read_index    (read_index),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_ready   (frame_ready),
        .frame_size    (frame_size),
        .read_data     (read_data),
        .receiver_mode (receiver_mode)
    );

    always #10 clk = ~clk;

    function automatic rx_result_t advance_frame_state(frame_item_t it);
        rx_result_t r;
        r.ready = 1'b0;
        r.rdata = 8'd0;
        case (it.op)
            CMD_BYTE:
            begin
                if (rx_mode == MODE_IDLE)
                begin
                    rx_mode = MODE_RECEIVING;
                    rx_count = 0;
                end
                if (rx_mode == MODE_RECEIVING)
                begin
                    if (rx_count >= FRAME_CAP)
                    begin
                        rx_mode = MODE_INVALID;
                        overflow_hits++;
                    end
                    else
                    begin
                        rx_store[rx_count] = it.data;
                        rx_count++;
                    end
                end
            end
            CMD_GAP_1P5:
            begin
                if (rx_mode == MODE_RECEIVING)
                    rx_mode = MODE_INVALID;
            end
            CMD_GAP_3P5:
            begin
                if (rx_mode == MODE_RECEIVING)
                begin
                    r.ready = 1'b1;
                    rx_held = rx_count;
                    frames_reported++;
                    if (rx_count > longest_frame)
                        longest_frame = rx_count;
                end
                rx_mode = MODE_IDLE;
                rx_count = 0;
            end
            default:
            begin
                if (int'(it.idx) < rx_held)
                begin
                    r.rdata = rx_store[it.idx];
                    reads_in_range++;
                end
            end
        endcase
        r.length = rx_held[FRAME_LENGTH_W-1:0];
        r.mode = rx_mode;
        return r;
    endfunction

    task automatic add_beat(cmd_t op, logic [7:0] data, logic [7:0] idx);
        frame_item_t it;
        it.op = op;
        it.data = data;
        it.idx = idx;
        it.pause = hold_next;
        hold_next = 1'b0;
        pending_beats.push_back(it);
    endtask

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Input acceptance, prediction and result checking.
    always @(posedge clk)
    begin
        frame_item_t it;
        rx_result_t  want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                it.op = cmd;
                it.data = data_byte;
                it.idx = read_index;
                it.pause = 1'b0;
                expected_results.push_back(advance_frame_state(it));
                beats_accepted++;
                beat_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("ERROR: result beat with nothing expected at %0t", $realtime);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (frame_ready !== want.ready || frame_size !== want.length
                        || read_data !== want.rdata || receiver_mode !== want.mode)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("ERROR: result %0d: expected ready=%0d len=%0d data=%02h mode=%0d",
                                     results_checked, want.ready, want.length, want.rdata,
                                     want.mode);
                            $display("       got ready=%0d len=%0d data=%02h mode=%0d",
                                     frame_ready, frame_size, read_data, receiver_mode);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Input driver with idle bursts and a drain pause on marked beats.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_taken))
        begin
            beat_taken = 1'b0;
            if (in_gap_left > 0)
            begin
                in_gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() == 0
                     || (pending_beats[0].pause && expected_results.size() != 0))
                in_valid <= 1'b0;
            else if (pending_beats.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
            begin
                in_gap_left = $urandom_range(0, 9);
                in_valid <= 1'b0;
            end
            else
            begin
                next_beat = pending_beats.pop_front();
                cmd <= next_beat.op;
                data_byte <= next_beat.data;
                read_index <= next_beat.idx;
                in_valid <= 1'b1;
            end
        end
    end

    // Output back-pressure in bursts, off during the final stretch.
    always @(negedge clk)
    begin
        if (out_gap_left > 0)
        begin
            out_gap_left--;
            out_stall <= 1'b1;
        end
        else if (rst_n && pending_beats.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
        begin
            out_gap_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("rtu_frame_receiver test failed");
        $finish;
    end

    initial
    begin
        int n;
        int cut;
        int limit;
        int directed_n;

        rx_mode = MODE_IDLE;
        rx_count = 0;
        rx_held = 0;
        foreach (rx_store[i])
            rx_store[i] = 8'd0;

        // Reads with nothing held, gaps in idle, a frame broken by a short gap,
        // bytes and gaps while invalid, a good frame with in- and out-of-range reads,
        // and a new frame overwriting the held bytes.
        add_beat(CMD_READ, 8'hFF, 8'd0);
        add_beat(CMD_READ, 8'h00, 8'd255);
        add_beat(CMD_GAP_1P5, 8'h00, 8'h00);
        add_beat(CMD_GAP_3P5, 8'hFF, 8'hFF);
        add_beat(CMD_BYTE, 8'h00, 8'hFF);
        add_beat(CMD_BYTE, 8'hFF, 8'h00);
        add_beat(CMD_GAP_1P5, 8'h12, 8'h34);
        add_beat(CMD_BYTE, 8'h77, 8'h00);
        add_beat(CMD_GAP_1P5, 8'h00, 8'h00);
        add_beat(CMD_GAP_3P5, 8'h00, 8'h00);
        add_beat(CMD_BYTE, 8'hA5, 8'h00);
        add_beat(CMD_BYTE, 8'h5A, 8'h00);
        add_beat(CMD_BYTE, 8'hFF, 8'h00);
        add_beat(CMD_GAP_3P5, 8'h00, 8'h00);
        add_beat(CMD_READ, 8'h00, 8'd0);
        add_beat(CMD_READ, 8'hFF, 8'd1);
        add_beat(CMD_READ, 8'h00, 8'd2);
        add_beat(CMD_READ, 8'h00, 8'd3);
        add_beat(CMD_READ, 8'h00, 8'd255);
        add_beat(CMD_BYTE, 8'h11, 8'h00);
        add_beat(CMD_READ, 8'h00, 8'd0);
        add_beat(CMD_READ, 8'h00, 8'd2);
        add_beat(CMD_GAP_3P5, 8'h00, 8'h00);
        add_beat(CMD_READ, 8'h00, 8'd0);
        directed_n = pending_beats.size();

        hold_next = 1'b1;
        while (pending_beats.size() - directed_n < RANDOM_BEATS)
        begin
            if ($urandom_range(0, 49) == 0)
                hold_next = 1'b1;
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 19) != 0)
                    add_beat(CMD_GAP_3P5, rnd8(), rnd8());
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(254, 257)
                                                 : $urandom_range(1, 16);
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
                for (int i = 0; i < n; i++)
                begin
                    if (i == cut)
                        add_beat(CMD_GAP_1P5, rnd8(), rnd8());
                    if ($urandom_range(0, 19) == 0)
                        add_beat(CMD_READ, rnd8(), rnd8());
                    add_beat(CMD_BYTE, rnd8(), rnd8());
                end
                add_beat(CMD_GAP_3P5, rnd8(), rnd8());
                limit = (n > 255) ? 255 : n;
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 4) != 0)
                        add_beat(CMD_READ, rnd8(), 8'($urandom_range(0, limit)));
                    else
                        add_beat(CMD_READ, rnd8(), rnd8());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                    add_beat(cmd_t'($urandom_range(0, 3)), rnd8(), rnd8());
            end
        end
        beats_total = pending_beats.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beats_accepted != beats_total || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Checked %0d results from %0d beats: %0d frames reported, longest %0d bytes.",
                 results_checked, beats_accepted, frames_reported, longest_frame);
        $display("Covered %0d in-range reads and %0d overflowing bytes; %0d mismatches.",
                 reads_in_range, overflow_hits, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("rtu_frame_receiver test passed");
        else
            $display("rtu_frame_receiver test failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl/core
rtl/core/rtu_rx_pkg.sv
rtl/core/rtu_frame_receiver.sv
tb/sv/tb_rtu_frame_receiver.sv
